>>> rtl/core/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and constants for the JSON string unescape block
// Result kinds, character codes, and the run descriptor that travels from
// the parser front end to the output serializer.
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam int unsigned FIFO_DEPTH_DEF = 4;

  // Result kinds as seen on the output tuser
  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_BSL   = 8'h5C;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_U     = 8'h75;

  localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF8_CONT  = 8'h80;
  localparam logic [15:0] UTF8_LIM1 = 16'h0080;
  localparam logic [15:0] UTF8_LIM2 = 16'h0800;

  // Results caused by one input beat: up to three data bytes, then an
  // optional done or error marker.
  typedef struct packed {
    logic [1:0]      nbytes;
    logic [2:0][7:0] bytes;
    logic            has_tail;
    kind_e           tail_kind;
  } desc_t;

endpackage

>>> rtl/core/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front: JSON string parser front end
// Tracks the parse phase, gathers \u digits and turns each accepted byte that
// yields results into a run descriptor for the output side.
// ----------------------------------------------------------------------------
module jsu_front
  import jsu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] in_byte_i,
  input  logic       start_i,
  input  logic       eoi_i,
  output logic       push_o,
  output desc_t      desc_o
);

  typedef enum logic [2:0] {
    PH_SEEK = 3'd0,
    PH_STR  = 3'd1,
    PH_ESC  = 3'd2,
    PH_HEX  = 3'd3,
    PH_IDLE = 3'd4
  } phase_e;

  phase_e      phase_q, phase_d, phase_cur;
  logic [15:0] hexv_q, hexv_d, hexv_cur, hex_next;
  logic [1:0]  hcnt_q, hcnt_d, hcnt_cur;
  logic        open_str;
  logic        nib_ok;
  logic [3:0]  nib;
  logic        is_ws;
  desc_t       desc;

  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic logic [7:0] map_escape(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    case (c)
      8'h62: r = 8'h08;
      8'h66: r = 8'h0C;
      8'h6E: r = 8'h0A;
      8'h72: r = 8'h0D;
      8'h74: r = 8'h09;
      default: r = c;
    endcase
    return r;
  endfunction

  assign {nib_ok, nib} = hex_nibble(in_byte_i);
  assign is_ws = (in_byte_i >= CHAR_TAB && in_byte_i <= CHAR_CR) || (in_byte_i == CHAR_SPACE);

  always_comb begin
    phase_cur = start_i ? PH_SEEK : phase_q;
    hexv_cur  = start_i ? 16'd0 : hexv_q;
    hcnt_cur  = start_i ? 2'd0 : hcnt_q;
    phase_d   = phase_cur;
    hexv_d    = hexv_cur;
    hcnt_d    = hcnt_cur;
    hex_next  = {hexv_cur[11:0], nib};
    open_str  = 1'b0;
    desc      = '0;

    unique case (phase_cur)
      PH_SEEK: begin
        if (is_ws) begin
          open_str = 1'b1;
        end else if (in_byte_i == CHAR_QUOTE) begin
          phase_d  = PH_STR;
          open_str = 1'b1;
        end else begin
          desc.has_tail  = 1'b1;
          desc.tail_kind = KIND_ERR;
          phase_d        = PH_IDLE;
        end
      end
      PH_STR: begin
        if (in_byte_i == CHAR_QUOTE) begin
          desc.has_tail  = 1'b1;
          desc.tail_kind = KIND_DONE;
          phase_d        = PH_IDLE;
        end else if (in_byte_i == CHAR_BSL) begin
          // a trailing backslash is passed on as itself before the error
          if (eoi_i) begin
            desc.nbytes   = 2'd1;
            desc.bytes[0] = CHAR_BSL;
          end
          phase_d  = PH_ESC;
          open_str = 1'b1;
        end else begin
          desc.nbytes   = 2'd1;
          desc.bytes[0] = in_byte_i;
          open_str      = 1'b1;
        end
      end
      PH_ESC: begin
        if (in_byte_i == CHAR_U) begin
          phase_d = PH_HEX;
          hexv_d  = '0;
          hcnt_d  = '0;
        end else begin
          desc.nbytes   = 2'd1;
          desc.bytes[0] = map_escape(in_byte_i);
          phase_d       = PH_STR;
        end
        open_str = 1'b1;
      end
      PH_HEX: begin
        if (!nib_ok) begin
          desc.has_tail  = 1'b1;
          desc.tail_kind = KIND_ERR;
          phase_d        = PH_IDLE;
          hexv_d         = '0;
          hcnt_d         = '0;
        end else begin
          open_str = 1'b1;
          if (hcnt_cur == 2'd3) begin
            // encode the code point as UTF-8
            if (hex_next < UTF8_LIM1) begin
              desc.nbytes   = 2'd1;
              desc.bytes[0] = hex_next[7:0];
            end else if (hex_next < UTF8_LIM2) begin
              desc.nbytes   = 2'd2;
              desc.bytes[0] = UTF8_LEAD2 | {3'b000, hex_next[10:6]};
              desc.bytes[1] = UTF8_CONT | {2'b00, hex_next[5:0]};
            end else begin
              desc.nbytes   = 2'd3;
              desc.bytes[0] = UTF8_LEAD3 | {4'b0000, hex_next[15:12]};
              desc.bytes[1] = UTF8_CONT | {2'b00, hex_next[11:6]};
              desc.bytes[2] = UTF8_CONT | {2'b00, hex_next[5:0]};
            end
            hexv_d  = '0;
            hcnt_d  = '0;
            phase_d = PH_STR;
          end else begin
            hexv_d = hex_next;
            hcnt_d = hcnt_cur + 2'd1;
          end
        end
      end
      PH_IDLE: begin
        phase_d = PH_IDLE;
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase

    // input ran out while the string is still open
    if (open_str && eoi_i) begin
      desc.has_tail  = 1'b1;
      desc.tail_kind = KIND_ERR;
      phase_d        = PH_IDLE;
      hexv_d         = '0;
      hcnt_d         = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEEK;
      hexv_q  <= '0;
      hcnt_q  <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      hexv_q  <= hexv_d;
      hcnt_q  <= hcnt_d;
    end
  end

  assign push_o = accept_i && ((desc.nbytes != 2'd0) || desc.has_tail);
  assign desc_o = desc;

endmodule

>>> rtl/core/jsu_fifo.sv
// ----------------------------------------------------------------------------
// jsu_fifo: run descriptor queue
// Short queue between parser and serializer so each side can stall alone.
// ----------------------------------------------------------------------------
module jsu_fifo
  import jsu_pkg::*;
#(
  parameter int unsigned Depth = FIFO_DEPTH_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t push_data_i,
  output logic  full_o,
  input  logic  pop_i,
  output desc_t pop_data_o,
  output logic  empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  desc_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == CntFull);
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("descriptor pushed into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("descriptor popped from empty queue");

endmodule

>>> rtl/core/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back: result serializer
// Holds one run descriptor; sends a result per cycle while tready is high.
// ----------------------------------------------------------------------------
module jsu_back
  import jsu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fifo_empty_i,
  input  desc_t      fifo_data_i,
  output logic       fifo_pop_o,
  output logic       m_tvalid_o,
  input  logic       m_tready_i,
  output logic [7:0] m_tdata_o,
  output kind_e      m_tuser_o,
  output logic       m_tlast_o
);

  desc_t      cur_q, cur_d;
  logic       valid_q, valid_d;
  logic [1:0] idx_q, idx_d;
  logic [2:0] total;
  logic       at_last, beat, load;

  assign total   = {1'b0, cur_q.nbytes} + {2'b00, cur_q.has_tail};
  assign at_last = ({1'b0, idx_q} + 3'd1) == total;
  assign beat    = valid_q && m_tready_i;
  assign load    = !valid_q || (beat && at_last);
  assign fifo_pop_o = load && !fifo_empty_i;

  always_comb begin
    cur_d   = cur_q;
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load) begin
      cur_d   = fifo_data_i;
      valid_d = !fifo_empty_i;
      idx_d   = '0;
    end else if (beat) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  always_comb begin
    m_tdata_o = '0;
    m_tuser_o = KIND_BYTE;
    if (idx_q < cur_q.nbytes) begin
      m_tdata_o = cur_q.bytes[idx_q];
    end else begin
      m_tuser_o = cur_q.tail_kind;
    end
  end

  assign m_tvalid_o = valid_q;
  assign m_tlast_o  = at_last;

  a_idx_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> ({1'b0, idx_q} < total))
    else $error("serializer index past end of run");

  a_marker_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && m_tuser_o != KIND_BYTE) |-> (m_tdata_o == 8'h00 && m_tlast_o))
    else $error("done or error marker must be last and carry zero");

  a_pop_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat && !at_last) |-> !fifo_pop_o)
    else $error("descriptor popped before run finished");

endmodule

>>> rtl/core/json_string_unescape_top.sv
// ----------------------------------------------------------------------------
// json_string_unescape_top: streaming JSON string decoder
// Takes JSON text one byte per beat, finds the opening quote, decodes
// escapes and \u code points to UTF-8, and reports done or error.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side: tdata carries the text byte, tuser restarts parsing (a
//   string is expected from this byte on), tlast marks the last byte of the
//   available text.
//   Master side: tdata is the decoded byte, tuser the result kind (byte,
//   done, error), tlast flags the final result caused by one input beat.
//   Whitespace before the quote, the quote itself, a backslash and \u
//   digits before the last give no result; a closing quote gives done.
//   After done or error the block drops bytes until tuser restarts it.
// Timing:
//   One input beat is accepted per cycle while the descriptor queue has room.
//   The first result of a beat reaches the master side through the queue
//   write and then the serializer load. Results leave at one beat per cycle
//   while tready is high; a beat that yields n results holds the serializer
//   for n output beats (at most four, a three-byte code point followed by an
//   end-of-text error).
//   New bytes are taken while earlier results still wait; the queue depth
//   absorbs bursts, and the serializer's output rate bounds the sustained input.
// Reset: parser returns to seeking the opening quote, queue and output empty.
// Stall: when the receiver holds tready low, results wait in the output
//   register and queue; input tready drops only when the queue is full.
// ----------------------------------------------------------------------------
module json_string_unescape_top
  import jsu_pkg::*;
#(
  parameter int unsigned FifoDepth = FIFO_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  logic       s_axis_tuser_i,   // [0] start_string
  input  logic       s_axis_tlast_i,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic [1:0] m_axis_tuser_o,   // [1:0] kind
  output logic       m_axis_tlast_o
);

  logic  s_accept;
  logic  push, fifo_full, fifo_empty, pop;
  desc_t push_desc, pop_desc;
  kind_e out_kind;

  // accept whenever the queue can take a descriptor
  assign s_axis_tready_o = !fifo_full;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  jsu_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (s_accept),
    .in_byte_i (s_axis_tdata_i),
    .start_i   (s_axis_tuser_i),
    .eoi_i     (s_axis_tlast_i),
    .push_o    (push),
    .desc_o    (push_desc)
  );

  jsu_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_desc),
    .full_o      (fifo_full),
    .pop_i       (pop),
    .pop_data_o  (pop_desc),
    .empty_o     (fifo_empty)
  );

  jsu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_empty_i (fifo_empty),
    .fifo_data_i  (pop_desc),
    .fifo_pop_o   (pop),
    .m_tvalid_o   (m_axis_tvalid_o),
    .m_tready_i   (m_axis_tready_i),
    .m_tdata_o    (m_axis_tdata_o),
    .m_tuser_o    (out_kind),
    .m_tlast_o    (m_axis_tlast_o)
  );

  assign m_axis_tuser_o = out_kind;

endmodule

>>> bench/tb_json_string_unescape_top.sv
// ----------------------------------------------------------------------------
// tb_json_string_unescape_top: self-checking bench for the JSON string decoder
// Feeds JSON text beats to the slave side: first a short directed table, then
// randomized strings with escapes, \u code points and noise. Each accepted
// beat runs through a behavioral decoder in the bench. Every result beat on
// the master side is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_json_string_unescape_top;
  import jsu_pkg::*;

  // Quiet cycles (no beat moving on either side) before the run is abandoned.
  // The worst honest stretch is a sender gap plus a long receiver stall plus
  // the trip through the queue and the serializer.
  localparam int QuietLimit  = 1000;
  // Cycles to hold after the last expected result, to catch stray beats.
  localparam int DrainCycles = 16;
  // Text beats in the whole run, directed table included.
  localparam int TotalBeats  = 170;

  // Decoder phases of the bench-side model
  typedef enum logic [2:0] {
    PH_SEEK,
    PH_STRING,
    PH_ESCAPE,
    PH_HEX,
    PH_IDLE
  } parse_phase_e;

  // One decoded result beat as it shows on the master side
  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
    logic       last;
  } result_t;

  // One text beat; typed rows carry their expected results inline
  typedef struct {
    logic [7:0] data;
    logic       restart;
    logic       eoi;
    logic       typed;
    int         n_typed;
    logic [7:0] t_data;
    kind_e      t_kind;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tuser = 1'b0;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [1:0] m_tuser;
  logic       m_tlast;

  // Bench copy of the decoder state
  parse_phase_e st_phase = PH_SEEK;
  logic [15:0]  st_hex = 16'h0000;
  logic [1:0]   st_cnt = 2'd0;

  result_t decoded_beat[$];   // results of the beat just accepted
  result_t pending_results[$];  // results still owed by the block

  int burst_left = 0;
  int beats_sent = 0;
  int live_beats = 0;
  int results_seen = 0;
  int bytes_seen = 0;
  int done_seen = 0;
  int errors_seen = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int rx_cycle = 0;
  int stall_left = 0;

  stim_row_t dir_rows [25];

  json_string_unescape_top dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),   // [7:0] in_byte
    .s_axis_tuser_i  (s_tuser),   // [0] start_string
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),   // [7:0] out_byte
    .m_axis_tuser_o  (m_tuser),   // [1:0] kind
    .m_axis_tlast_o  (m_tlast)
  );

  always #5 clk = ~clk;

  // Value of a hex digit in either case, or -1 for anything else
  function automatic int hex_digit_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  // Advance the bench decoder by one text beat and collect what it yields
  task automatic decode_beat(input logic [7:0] c, input logic restart, input logic eoi);
    logic       stay_open;
    int         nib;
    logic [7:0] mapped;
    stay_open = 1'b0;
    decoded_beat.delete();
    // A restart wins over any phase, idle included
    if (restart) begin
      st_phase = PH_SEEK;
      st_hex = 16'h0000;
      st_cnt = 2'd0;
    end
    case (st_phase)
      PH_SEEK: begin
        if ((c >= CHAR_TAB && c <= CHAR_CR) || c == CHAR_SPACE) begin
          stay_open = 1'b1;
        end else if (c == CHAR_QUOTE) begin
          st_phase = PH_STRING;
          stay_open = 1'b1;
        end else begin
          decoded_beat.push_back('{data: 8'h00, kind: KIND_ERR, last: 1'b0});
          st_phase = PH_IDLE;
        end
      end
      PH_STRING: begin
        if (c == CHAR_QUOTE) begin
          decoded_beat.push_back('{data: 8'h00, kind: KIND_DONE, last: 1'b0});
          st_phase = PH_IDLE;
        end else if (c == CHAR_BSL) begin
          // A dangling backslash at end of text still comes out as itself
          if (eoi) decoded_beat.push_back('{data: CHAR_BSL, kind: KIND_BYTE, last: 1'b0});
          st_phase = PH_ESCAPE;
          stay_open = 1'b1;
        end else begin
          decoded_beat.push_back('{data: c, kind: KIND_BYTE, last: 1'b0});
          stay_open = 1'b1;
        end
      end
      PH_ESCAPE: begin
        if (c == CHAR_U) begin
          st_phase = PH_HEX;
          st_hex = 16'h0000;
          st_cnt = 2'd0;
        end else begin
          case (c)
            "b":     mapped = 8'h08;
            "f":     mapped = 8'h0C;
            "n":     mapped = 8'h0A;
            "r":     mapped = CHAR_CR;
            "t":     mapped = CHAR_TAB;
            default: mapped = c;  // quote, backslash, slash and unknown ones
          endcase
          decoded_beat.push_back('{data: mapped, kind: KIND_BYTE, last: 1'b0});
          st_phase = PH_STRING;
        end
        stay_open = 1'b1;
      end
      PH_HEX: begin
        nib = hex_digit_value(c);
        if (nib < 0) begin
          // Drop the whole escape; no end-of-text error on top of this one
          decoded_beat.push_back('{data: 8'h00, kind: KIND_ERR, last: 1'b0});
          st_phase = PH_IDLE;
          st_hex = 16'h0000;
          st_cnt = 2'd0;
        end else begin
          st_hex = {st_hex[11:0], nib[3:0]};
          if (st_cnt == 2'd3) begin
            if (st_hex < UTF8_LIM1) begin
              decoded_beat.push_back('{data: st_hex[7:0], kind: KIND_BYTE, last: 1'b0});
            end else if (st_hex < UTF8_LIM2) begin
              decoded_beat.push_back('{data: UTF8_LEAD2 | {3'b000, st_hex[10:6]},
                                       kind: KIND_BYTE, last: 1'b0});
              decoded_beat.push_back('{data: UTF8_CONT | {2'b00, st_hex[5:0]},
                                       kind: KIND_BYTE, last: 1'b0});
            end else begin
              decoded_beat.push_back('{data: UTF8_LEAD3 | {4'h0, st_hex[15:12]},
                                       kind: KIND_BYTE, last: 1'b0});
              decoded_beat.push_back('{data: UTF8_CONT | {2'b00, st_hex[11:6]},
                                       kind: KIND_BYTE, last: 1'b0});
              decoded_beat.push_back('{data: UTF8_CONT | {2'b00, st_hex[5:0]},
                                       kind: KIND_BYTE, last: 1'b0});
            end
            st_hex = 16'h0000;
            st_cnt = 2'd0;
            st_phase = PH_STRING;
          end else begin
            st_cnt = st_cnt + 2'd1;
          end
          stay_open = 1'b1;
        end
      end
      default: st_phase = PH_IDLE;  // idle: drop the beat, ignore tlast
    endcase
    // Text ran out while the string was still open
    if (stay_open && eoi) begin
      decoded_beat.push_back('{data: 8'h00, kind: KIND_ERR, last: 1'b0});
      st_phase = PH_IDLE;
      st_hex = 16'h0000;
      st_cnt = 2'd0;
    end
    if (decoded_beat.size() > 0) decoded_beat[decoded_beat.size() - 1].last = 1'b1;
  endtask

  // Present one text beat in sender bursts, wait for the handshake and
  // record what the block now owes
  task automatic send_beat(input stim_row_t row);
    int gap;
    // Between bursts, drop tvalid for a random gap (sometimes none)
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = int'($urandom_range(1, 16));
    end
    s_tvalid <= 1'b1;
    s_tdata  <= row.data;
    s_tuser  <= row.restart;
    s_tlast  <= row.eoi;
    do @(posedge clk); while (!s_tready);
    burst_left--;
    beats_sent++;
    if (st_phase != PH_IDLE || row.restart) live_beats++;
    decode_beat(row.data, row.restart, row.eoi);
    if (row.typed) begin
      for (int i = 0; i < row.n_typed; i++)
        pending_results.push_back('{data: row.t_data, kind: row.t_kind,
                                    last: (i == row.n_typed - 1)});
    end else begin
      foreach (decoded_beat[i]) pending_results.push_back(decoded_beat[i]);
    end
  endtask

  // Send one text byte of a random string unless the text already ended;
  // tlast falls now and then on any byte
  task automatic send_text(input logic [7:0] c, inout logic first, inout logic ended);
    stim_row_t row;
    if (!ended) begin
      row = '{data: c, restart: first, eoi: ($urandom_range(0, 49) == 0), typed: 1'b0,
              n_typed: 0, t_data: 8'h00, t_kind: KIND_BYTE};
      send_beat(row);
      first = 1'b0;
      ended = row.eoi;
    end
  endtask

  // Mostly well-formed string: restart, optional whitespace, opening quote,
  // a mix of plain bytes and escapes, closing quote, some idle junk after it
  task automatic send_string();
    logic        first;
    logic        ended;
    int          sel;
    int          bad_digit;
    int          k;
    logic [15:0] code_point;
    logic [3:0]  nibble;
    logic [7:0]  c;
    logic [7:0]  alpha_base;
    stim_row_t   junk;
    first = 1'b1;
    ended = 1'b0;
    repeat ($urandom_range(0, 2)) begin
      sel = int'($urandom_range(0, 5));
      c = (sel == 5) ? CHAR_SPACE : CHAR_TAB + 8'(sel);
      send_text(c, first, ended);
    end
    send_text(CHAR_QUOTE, first, ended);
    repeat ($urandom_range(0, 8)) begin
      sel = int'($urandom_range(0, 9));
      if (sel <= 3) begin
        // Plain byte over the full range, minus the two that change phase
        c = 8'($urandom_range(0, 255));
        if (c == CHAR_QUOTE || c == CHAR_BSL) c = "a";
        send_text(c, first, ended);
      end else if (sel <= 5) begin
        send_text(CHAR_BSL, first, ended);
        case ($urandom_range(0, 7))
          0:       c = CHAR_QUOTE;
          1:       c = CHAR_BSL;
          2:       c = "/";
          3:       c = "b";
          4:       c = "f";
          5:       c = "n";
          6:       c = "r";
          default: c = "t";
        endcase
        send_text(c, first, ended);
      end else if (sel == 6) begin
        // Unknown escape stands for itself
        send_text(CHAR_BSL, first, ended);
        c = 8'($urandom_range(0, 255));
        if (c == CHAR_U) c = "x";
        send_text(c, first, ended);
      end else if (sel <= 8) begin
        send_text(CHAR_BSL, first, ended);
        send_text(CHAR_U, first, ended);
        // Spread code points over the one, two and three byte encodings
        case ($urandom_range(0, 3))
          0:       code_point = 16'($urandom_range(0, 'h7F));
          1:       code_point = 16'($urandom_range('h80, 'h7FF));
          2:       code_point = 16'($urandom_range('h800, 'hFFFF));
          default: code_point = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
        endcase
        bad_digit = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 3)) : 4;
        for (k = 3; k >= 0; k--) begin
          nibble = code_point[k*4 +: 4];
          alpha_base = ($urandom_range(0, 1) == 1) ? "A" : "a";
          if (k == bad_digit) begin
            do c = 8'($urandom_range(0, 255)); while (hex_digit_value(c) >= 0);
          end else if (nibble < 4'd10) begin
            c = "0" + {4'h0, nibble};
          end else begin
            c = alpha_base + {4'h0, nibble} - 8'd10;
          end
          send_text(c, first, ended);
          // A bad digit kills the string; stop here
          if (k == bad_digit) ended = 1'b1;
        end
      end else begin
        // Restart in the middle of a string
        first = 1'b1;
        c = ($urandom_range(0, 1) == 1) ? CHAR_QUOTE : 8'($urandom_range(0, 255));
        send_text(c, first, ended);
      end
    end
    if ($urandom_range(0, 9) != 0) send_text(CHAR_QUOTE, first, ended);
    // Junk after the string: dropped, tlast included, if the block is idle by then
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        junk = '{data: 8'($urandom_range(0, 255)), restart: 1'b0,
                 eoi: ($urandom_range(0, 1) == 1), typed: 1'b0, n_typed: 0,
                 t_data: 8'h00, t_kind: KIND_BYTE};
        send_beat(junk);
      end
    end
  endtask

  // Short bursts of fully random beats
  task automatic send_noise();
    stim_row_t row;
    repeat ($urandom_range(1, 6)) begin
      row = '{data: 8'($urandom_range(0, 255)), restart: ($urandom_range(0, 3) == 0),
              eoi: ($urandom_range(0, 7) == 0), typed: 1'b0, n_typed: 0,
              t_data: 8'h00, t_kind: KIND_BYTE};
      send_beat(row);
    end
  endtask

  task automatic report_mismatch(input string field, input int got, input int want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch on result %0d, %s: got 0x%0h, expected 0x%0h",
               results_seen, field, got, want);
  endtask

  // Stimulus: reset, directed table, random strings, then drain
  initial begin
    // Directed rows; typed ones give their result outright, the rest
    // rely on the bench decoder
    dir_rows = '{
      '{8'h41,      1'b0, 1'b0, 1'b1, 1, 8'h00, KIND_ERR},   // non-quote after reset
      '{CHAR_SPACE, 1'b1, 1'b0, 1'b1, 0, 8'h00, KIND_BYTE},  // restart on whitespace
      '{CHAR_CR,    1'b0, 1'b0, 1'b1, 0, 8'h00, KIND_BYTE},
      '{CHAR_QUOTE, 1'b0, 1'b0, 1'b1, 0, 8'h00, KIND_BYTE},  // opening quote
      '{8'h00,      1'b0, 1'b0, 1'b1, 1, 8'h00, KIND_BYTE},  // lowest byte
      '{8'hFF,      1'b0, 1'b0, 1'b1, 1, 8'hFF, KIND_BYTE},  // highest byte
      '{CHAR_BSL,   1'b0, 1'b0, 1'b1, 0, 8'h00, KIND_BYTE},
      '{"b",        1'b0, 1'b0, 1'b0, 0, 8'h00, KIND_BYTE},
      '{CHAR_BSL,   1'b0, 1'b0, 1'b1, 0, 8'h00, KIND_BYTE},  // \u0000: byte zero
      '{CHAR_U,     1'b0, 1'b0, 1'b1, 0, 8'h00, KIND_BYTE},
      '{"0",        1'b0, 1'b0, 1'b1, 0, 8'h00, KIND_BYTE},
      '{"0",        1'b0, 1'b0, 1'b1, 0, 8'h00, KIND_BYTE},
      '{"0",        1'b0, 1'b0, 1'b1, 0, 8'h00, KIND_BYTE},
      '{"0",        1'b0, 1'b0, 1'b0, 0, 8'h00, KIND_BYTE},
      '{CHAR_BSL,   1'b0, 1'b0, 1'b1, 0, 8'h00, KIND_BYTE},  // \uFFFF ending the text
      '{CHAR_U,     1'b0, 1'b0, 1'b1, 0, 8'h00, KIND_BYTE},
      '{"F",        1'b0, 1'b0, 1'b1, 0, 8'h00, KIND_BYTE},
      '{"F",        1'b0, 1'b0, 1'b1, 0, 8'h00, KIND_BYTE},
      '{"f",        1'b0, 1'b0, 1'b1, 0, 8'h00, KIND_BYTE},
      '{"F",        1'b0, 1'b1, 1'b0, 0, 8'h00, KIND_BYTE},
      '{CHAR_QUOTE, 1'b1, 1'b0, 1'b1, 0, 8'h00, KIND_BYTE},  // restart from idle
      '{CHAR_QUOTE, 1'b0, 1'b1, 1'b1, 1, 8'h00, KIND_DONE},  // close on the last byte
      '{8'h41,      1'b0, 1'b0, 1'b1, 0, 8'h00, KIND_BYTE},  // dropped while idle
      '{CHAR_QUOTE, 1'b1, 1'b0, 1'b1, 0, 8'h00, KIND_BYTE},
      '{CHAR_BSL,   1'b0, 1'b1, 1'b0, 0, 8'h00, KIND_BYTE}   // lone backslash at end
    };
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[i]) send_beat(dir_rows[i]);
    while (beats_sent < TotalBeats) begin
      if ($urandom_range(0, 4) == 0) send_noise();
      else send_string();
    end
    s_tvalid <= 1'b0;
    // Hold until every owed result has come out, then watch for stray beats
    while (pending_results.size() > 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    $display("covered %0d text beats, %0d of them parsed and the rest dropped while idle",
             beats_sent, live_beats);
    $display("checked %0d results: %0d bytes, %0d done, %0d errors; %0d mismatches",
             results_seen, bytes_seen, done_seen, errors_seen, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Receiver: rotate through always-ready, coin-flip, one-in-four and
  // long-stall patterns, one after another.
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    case ((rx_cycle >> 7) % 4)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 1) == 1);
      2: m_tready <= (rx_cycle % 4 == 0);
      default: begin
        if (stall_left > 0) begin
          m_tready <= 1'b0;
          stall_left <= stall_left - 1;
        end else begin
          m_tready <= 1'b1;
          if ($urandom_range(0, 3) == 0) stall_left <= int'($urandom_range(1, 20));
        end
      end
    endcase
  end

  // Result checker: compare each accepted result beat with the oldest one owed
  always @(posedge clk) begin
    result_t want;
    if (rst_n && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat, data", int'(m_tdata), 0);
      end else begin
        want = pending_results.pop_front();
        case (want.kind)
          KIND_BYTE: bytes_seen++;
          KIND_DONE: done_seen++;
          default:   errors_seen++;
        endcase
        if (m_tdata !== want.data) report_mismatch("out_byte", int'(m_tdata), int'(want.data));
        if (m_tuser !== want.kind) report_mismatch("kind", int'(m_tuser), int'(want.kind));
        if (m_tlast !== want.last) report_mismatch("last_of_run", int'(m_tlast), int'(want.last));
      end
    end
  end

  // Watchdog: abandon the run when no beat moves for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("timeout: no beat moved for %0d cycles, %0d results still owed",
               quiet_cycles, pending_results.size());
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
